### rtl/core/kfc_pkg.sv
// kfc_pkg: shared types and constants of the frame classifier
// no dependencies; every other file of the block takes its names by scope
package kfc_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_SERVICE_PORT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RECORD_MARK  = 1'd1;

	localparam logic [15:0] SERVICE_PORT_RST = 16'd88;
	localparam logic [3:0]  RECORD_MARK_RST  = 4'd4;

	// ethernet / ip constants
	localparam logic [15:0] ETH_IPV4   = 16'h0800;
	localparam logic [7:0]  IPP_ICMP   = 8'd1;
	localparam logic [7:0]  IPP_IGMP   = 8'd2;
	localparam logic [7:0]  IPP_TCP    = 8'd6;
	localparam logic [7:0]  IPP_UDP    = 8'd17;

	// message tags
	localparam logic [7:0] TAG_AS_REQ  = 8'h6a;
	localparam logic [7:0] TAG_AS_REP  = 8'h6b;
	localparam logic [7:0] TAG_TGS_REQ = 8'h6c;
	localparam logic [7:0] TAG_TGS_REP = 8'h6d;
	localparam logic [7:0] TAG_ERROR   = 8'h7e;

	// ber length bytes
	localparam logic [7:0] BER_LONG    = 8'd128;
	localparam logic [7:0] BER_RESV    = 8'd255;
	localparam logic [7:0] BER_MAX_LEN = 8'd132;

	typedef enum logic [2:0] {
		PC_ICMP  = 3'd0,
		PC_IGMP  = 3'd1,
		PC_TCP   = 3'd2,
		PC_UDP   = 3'd3,
		PC_OTHER = 3'd4
	} proto_class_t;

	typedef enum logic [2:0] {
		MK_NONE    = 3'd0,
		MK_AS_REQ  = 3'd1,
		MK_AS_REP  = 3'd2,
		MK_TGS_REQ = 3'd3,
		MK_TGS_REP = 3'd4,
		MK_ERROR   = 3'd5,
		MK_OTHER   = 3'd6
	} msg_kind_t;

	// frame counter slots
	localparam int CNT_NUM = 7;
	localparam logic [2:0] CNT_TOTAL = 3'd0;
	localparam logic [2:0] CNT_TCP   = 3'd1;
	localparam logic [2:0] CNT_UDP   = 3'd2;
	localparam logic [2:0] CNT_ICMP  = 3'd3;
	localparam logic [2:0] CNT_IGMP  = 3'd4;
	localparam logic [2:0] CNT_OTHER = 3'd5;
	localparam logic [2:0] CNT_KRB   = 3'd6;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_end;
	} item_t;

	typedef struct packed {
		logic [15:0] service_port;
		logic [3:0]  record_mark_bytes;
	} cfg_t;

	typedef struct packed {
		proto_class_t proto_class;
		logic         is_kerberos;
		msg_kind_t    message_kind;
		logic [31:0]  message_length;
		logic         length_ok;
	} result_t;

endpackage

### rtl/core/kfc_if.sv
// kfc_if: valid/ready channel interfaces of the frame classifier
// byte channel, result channel and configuration write channel; uses kfc_pkg
interface kfc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       frame_end;

	modport source (output valid, frame_byte, frame_end, input ready);
	modport sink (input valid, frame_byte, frame_end, output ready);
endinterface

interface kfc_result_if #(
	parameter int COUNT_BITS = 32
);
	logic                  valid;
	logic                  ready;
	logic [2:0]            proto_class;
	logic                  is_kerberos;
	logic [2:0]            message_kind;
	logic [31:0]           message_length;
	logic                  length_ok;
	logic [COUNT_BITS-1:0] total_frames;
	logic [COUNT_BITS-1:0] tcp_frames;
	logic [COUNT_BITS-1:0] udp_frames;
	logic [COUNT_BITS-1:0] icmp_frames;
	logic [COUNT_BITS-1:0] igmp_frames;
	logic [COUNT_BITS-1:0] other_frames;
	logic [COUNT_BITS-1:0] kerberos_frames;

	modport source (output valid, proto_class, is_kerberos, message_kind, message_length,
		length_ok, total_frames, tcp_frames, udp_frames, icmp_frames, igmp_frames,
		other_frames, kerberos_frames, input ready);
	modport sink (input valid, proto_class, is_kerberos, message_kind, message_length,
		length_ok, total_frames, tcp_frames, udp_frames, icmp_frames, igmp_frames,
		other_frames, kerberos_frames, output ready);
endinterface

interface kfc_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [kfc_pkg::CFG_IDX_W-1:0] index;
	logic [15:0]                   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/kerberos_frame_classifier.sv
// kerberos_frame_classifier: top level of the ethernet/ipv4/tcp frame classifier
// depends on kfc_pkg, kfc_if, kfc_cfg, kfc_in_reg, kfc_parse, kfc_out_reg
//
//  channel   dir  handshake        payload
//  frame     in   valid / ready    frame_byte[7:0], frame_end
//  result    out  valid / ready    class, kerberos flag, message kind/length, 7 counters
//  cfg       in   valid / ready    index (0 service_port, 1 record_mark_bytes), data[15:0]
//
// one byte per cycle sustained while no last byte waits on a full result register;
// each byte is held in the input register, and a frame's result is registered at the
// edge its last byte leaves that register and is offered from the result register
// reset clears the input and result valid bits, all frame tracking state and counters,
// and loads service_port = 88 and record_mark_bytes = 4; cfg is always ready
// only a last byte waits on a full result register: other bytes keep flowing
// while an earlier result is still held
module kerberos_frame_classifier #(
	parameter int OFFSET_BITS = 16,
	parameter int COUNT_BITS  = 32
) (
	input logic       clk,
	input logic       arst_n,
	kfc_byte_if.sink  frame,
	kfc_result_if.source result,
	kfc_cfg_if.sink   cfg
);

	kfc_pkg::cfg_t         cfg_regs;
	kfc_pkg::item_t        in_item;
	kfc_pkg::item_t        item_s1;
	logic                  valid_s1;
	logic                  take_s1;
	logic                  out_free;
	kfc_pkg::result_t      parse_res;
	kfc_pkg::result_t      res_data;
	logic [COUNT_BITS-1:0] cnt [kfc_pkg::CNT_NUM];

	// configuration writes land immediately
	assign cfg.ready = 1'b1;

	kfc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_regs)
	);

	assign in_item.frame_byte = frame.frame_byte;
	assign in_item.frame_end  = frame.frame_end;

	kfc_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (frame.valid),
		.in_item  (in_item),
		.in_ready (frame.ready),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.take_s1  (take_s1)
	);

	// a last byte needs room in the result register, any other byte moves on
	assign take_s1 = valid_s1 && (!item_s1.frame_end || out_free);

	kfc_parse #(
		.OFFSET_BITS (OFFSET_BITS),
		.COUNT_BITS  (COUNT_BITS)
	) u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (take_s1),
		.item   (item_s1),
		.cfg    (cfg_regs),
		.result (parse_res),
		.cnt    (cnt)
	);

	kfc_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take_s1 && item_s1.frame_end),
		.load_data (parse_res),
		.out_ready (result.ready),
		.out_valid (result.valid),
		.out_data  (res_data),
		.free      (out_free)
	);

	assign result.proto_class    = res_data.proto_class;
	assign result.is_kerberos    = res_data.is_kerberos;
	assign result.message_kind   = res_data.message_kind;
	assign result.message_length = res_data.message_length;
	assign result.length_ok      = res_data.length_ok;

	// counters only move when a result is loaded, so they hold while it waits
	assign result.total_frames    = cnt[kfc_pkg::CNT_TOTAL];
	assign result.tcp_frames      = cnt[kfc_pkg::CNT_TCP];
	assign result.udp_frames      = cnt[kfc_pkg::CNT_UDP];
	assign result.icmp_frames     = cnt[kfc_pkg::CNT_ICMP];
	assign result.igmp_frames     = cnt[kfc_pkg::CNT_IGMP];
	assign result.other_frames    = cnt[kfc_pkg::CNT_OTHER];
	assign result.kerberos_frames = cnt[kfc_pkg::CNT_KRB];

endmodule

### rtl/core/kfc_cfg.sv
// kfc_cfg: configuration registers (service port, record mark length)
// uses kfc_pkg for register indexes and reset values
module kfc_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_valid,
	input  logic [kfc_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [15:0]                   wr_data,
	output kfc_pkg::cfg_t                 cfg
);

	logic [15:0] service_port_q;
	logic [3:0]  record_mark_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			service_port_q <= kfc_pkg::SERVICE_PORT_RST;
			record_mark_q  <= kfc_pkg::RECORD_MARK_RST;
		end else if (wr_valid) begin
			unique case (wr_index)
				kfc_pkg::CFG_SERVICE_PORT: service_port_q <= wr_data;
				kfc_pkg::CFG_RECORD_MARK:  record_mark_q  <= wr_data[3:0];
				default: ;
			endcase
		end
	end

	assign cfg.service_port      = service_port_q;
	assign cfg.record_mark_bytes = record_mark_q;

endmodule

### rtl/core/kfc_in_reg.sv
// kfc_in_reg: input register stage holding one frame byte
// uses kfc_pkg::item_t
module kfc_in_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  kfc_pkg::item_t in_item,
	output logic           in_ready,
	output logic           valid_s1,
	output kfc_pkg::item_t item_s1,
	input  logic           take_s1
);

	logic load;

	assign in_ready = !valid_s1 || take_s1;
	assign load     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (take_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= in_item;
		end
	end

endmodule

### rtl/core/kfc_parse.sv
// kfc_parse: per-frame header tracking, classification and frame counters
// uses kfc_pkg types and constants; fed by kfc_in_reg, drives kfc_out_reg
module kfc_parse #(
	parameter int OFFSET_BITS = 16,
	parameter int COUNT_BITS  = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  kfc_pkg::item_t        item,
	input  kfc_pkg::cfg_t         cfg,
	output kfc_pkg::result_t      result,
	output logic [COUNT_BITS-1:0] cnt [kfc_pkg::CNT_NUM]
);

	typedef enum logic [1:0] {
		LF_IDLE = 2'd0,
		LF_READ = 2'd1,
		LF_DONE = 2'd2,
		LF_BAD  = 2'd3
	} len_flag_t;

	localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

	logic [OFFSET_BITS-1:0] byte_offset_q;
	logic [15:0]            ether_kind_q, ether_kind_n;
	logic                   ip_ver_ok_q, ip_ver_ok_n;
	logic [5:0]             ip_hdr_q, ip_hdr_n;
	logic [7:0]             ip_proto_q, ip_proto_n;
	logic [15:0]            src_port_q, src_port_n;
	logic [15:0]            dst_port_q, dst_port_n;
	logic [5:0]             tcp_hdr_q, tcp_hdr_n;
	logic [7:0]             msg_tag_q, msg_tag_n;
	logic                   tag_seen_q, tag_seen_n;
	logic [2:0]             len_left_q, len_left_n;
	logic [31:0]            len_accum_q, len_accum_n;
	len_flag_t              len_flag_q, len_flag_n;
	logic [COUNT_BITS-1:0]  cnt_q [kfc_pkg::CNT_NUM];

	logic [OFFSET_BITS-1:0] pos;
	logic [7:0]             b;
	logic [6:0]             tcp_start;
	logic [OFFSET_BITS-1:0] ts;
	logic [7:0]             tag_pos;
	logic [7:0]             tag_pos1;
	logic                   in_ip;
	logic                   in_tag;
	logic                   port_match;
	logic                   krb;
	kfc_pkg::proto_class_t  cls;
	kfc_pkg::msg_kind_t     kind;
	logic [2:0]             cls_slot;

	assign pos       = byte_offset_q;
	assign b         = item.frame_byte;
	assign tcp_start = 7'd14 + {1'b0, ip_hdr_q};
	assign ts        = OFFSET_BITS'(tcp_start);
	assign tag_pos   = {1'b0, tcp_start} + {2'b00, tcp_hdr_q} + {4'b0000, cfg.record_mark_bytes};
	assign tag_pos1  = tag_pos + 8'd1;
	assign in_ip     = (pos > OFFSET_BITS'(14)) && (ip_hdr_q >= 6'd20);
	assign in_tag    = in_ip && (tcp_hdr_q >= 6'd20) && (pos > ts + OFFSET_BITS'(12));

	// next frame state for this byte
	always_comb begin
		ether_kind_n = ether_kind_q;
		ip_ver_ok_n  = ip_ver_ok_q;
		ip_hdr_n     = ip_hdr_q;
		ip_proto_n   = ip_proto_q;
		src_port_n   = src_port_q;
		dst_port_n   = dst_port_q;
		tcp_hdr_n    = tcp_hdr_q;
		msg_tag_n    = msg_tag_q;
		tag_seen_n   = tag_seen_q;
		len_left_n   = len_left_q;
		len_accum_n  = len_accum_q;
		len_flag_n   = len_flag_q;

		if (pos == OFFSET_BITS'(12)) begin
			ether_kind_n[15:8] = b;
		end else if (pos == OFFSET_BITS'(13)) begin
			ether_kind_n[7:0] = b;
		end else if (pos == OFFSET_BITS'(14)) begin
			ip_ver_ok_n = (b[7:4] == 4'd4);
			ip_hdr_n    = {b[3:0], 2'b00};
		end else if (pos == OFFSET_BITS'(23)) begin
			ip_proto_n = b;
		end

		if (in_ip) begin
			if (pos == ts) begin
				src_port_n[15:8] = b;
			end else if (pos == ts + OFFSET_BITS'(1)) begin
				src_port_n[7:0] = b;
			end else if (pos == ts + OFFSET_BITS'(2)) begin
				dst_port_n[15:8] = b;
			end else if (pos == ts + OFFSET_BITS'(3)) begin
				dst_port_n[7:0] = b;
			end else if (pos == ts + OFFSET_BITS'(12)) begin
				tcp_hdr_n = {b[7:4], 2'b00};
			end
		end

		if (in_tag) begin
			if (pos == OFFSET_BITS'(tag_pos)) begin
				tag_seen_n  = 1'b1;
				msg_tag_n   = b;
				len_flag_n  = LF_IDLE;
				len_left_n  = 3'd0;
				len_accum_n = 32'd0;
			end else if (tag_seen_q && msg_tag_q == kfc_pkg::TAG_AS_REQ &&
					pos == OFFSET_BITS'(tag_pos1)) begin
				// first length byte: short form, reserved forms, or octet count
				if (b < kfc_pkg::BER_LONG) begin
					len_accum_n = {24'd0, b};
					len_flag_n  = LF_DONE;
				end else if (b == kfc_pkg::BER_LONG || b == kfc_pkg::BER_RESV ||
						b > kfc_pkg::BER_MAX_LEN) begin
					len_flag_n = LF_BAD;
				end else begin
					len_left_n  = b[2:0];
					len_accum_n = 32'd0;
					len_flag_n  = LF_READ;
				end
			end else if (len_flag_q == LF_READ && pos > OFFSET_BITS'(tag_pos1)) begin
				len_accum_n = {len_accum_q[23:0], b};
				len_left_n  = len_left_q - 3'd1;
				if (len_left_n == 3'd0) begin
					len_flag_n = LF_DONE;
				end
			end
		end
	end

	// classification of the frame as it stands after this byte
	always_comb begin
		if (pos < OFFSET_BITS'(23)) begin
			cls = kfc_pkg::PC_OTHER;
		end else begin
			case (ip_proto_n)
				kfc_pkg::IPP_ICMP: cls = kfc_pkg::PC_ICMP;
				kfc_pkg::IPP_IGMP: cls = kfc_pkg::PC_IGMP;
				kfc_pkg::IPP_TCP:  cls = kfc_pkg::PC_TCP;
				kfc_pkg::IPP_UDP:  cls = kfc_pkg::PC_UDP;
				default:           cls = kfc_pkg::PC_OTHER;
			endcase
		end
	end

	assign port_match = (src_port_n == cfg.service_port) || (dst_port_n == cfg.service_port);
	assign krb = (ether_kind_n == kfc_pkg::ETH_IPV4) && ip_ver_ok_n && (ip_hdr_n >= 6'd20) &&
		(cls == kfc_pkg::PC_TCP) && (pos >= ts + OFFSET_BITS'(3)) && port_match;

	always_comb begin
		if (krb && tag_seen_n) begin
			unique case (msg_tag_n)
				kfc_pkg::TAG_AS_REQ:  kind = kfc_pkg::MK_AS_REQ;
				kfc_pkg::TAG_AS_REP:  kind = kfc_pkg::MK_AS_REP;
				kfc_pkg::TAG_TGS_REQ: kind = kfc_pkg::MK_TGS_REQ;
				kfc_pkg::TAG_TGS_REP: kind = kfc_pkg::MK_TGS_REP;
				kfc_pkg::TAG_ERROR:   kind = kfc_pkg::MK_ERROR;
				default:              kind = kfc_pkg::MK_OTHER;
			endcase
		end else begin
			kind = kfc_pkg::MK_NONE;
		end
	end

	always_comb begin
		result.proto_class    = cls;
		result.is_kerberos    = krb;
		result.message_kind   = kind;
		result.length_ok      = (kind == kfc_pkg::MK_AS_REQ) && (len_flag_n == LF_DONE);
		result.message_length = result.length_ok ? len_accum_n : 32'd0;
	end

	always_comb begin
		case (cls)
			kfc_pkg::PC_TCP:  cls_slot = kfc_pkg::CNT_TCP;
			kfc_pkg::PC_UDP:  cls_slot = kfc_pkg::CNT_UDP;
			kfc_pkg::PC_ICMP: cls_slot = kfc_pkg::CNT_ICMP;
			kfc_pkg::PC_IGMP: cls_slot = kfc_pkg::CNT_IGMP;
			default:          cls_slot = kfc_pkg::CNT_OTHER;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_offset_q <= '0;
			ether_kind_q  <= '0;
			ip_ver_ok_q   <= 1'b0;
			ip_hdr_q      <= '0;
			ip_proto_q    <= '0;
			src_port_q    <= '0;
			dst_port_q    <= '0;
			tcp_hdr_q     <= '0;
			msg_tag_q     <= '0;
			tag_seen_q    <= 1'b0;
			len_left_q    <= '0;
			len_accum_q   <= '0;
			len_flag_q    <= LF_IDLE;
		end else if (step) begin
			if (item.frame_end) begin
				byte_offset_q <= '0;
				ether_kind_q  <= '0;
				ip_ver_ok_q   <= 1'b0;
				ip_hdr_q      <= '0;
				ip_proto_q    <= '0;
				src_port_q    <= '0;
				dst_port_q    <= '0;
				tcp_hdr_q     <= '0;
				msg_tag_q     <= '0;
				tag_seen_q    <= 1'b0;
				len_left_q    <= '0;
				len_accum_q   <= '0;
				len_flag_q    <= LF_IDLE;
			end else begin
				if (byte_offset_q != OFF_MAX) begin
					byte_offset_q <= byte_offset_q + OFFSET_BITS'(1);
				end
				ether_kind_q <= ether_kind_n;
				ip_ver_ok_q  <= ip_ver_ok_n;
				ip_hdr_q     <= ip_hdr_n;
				ip_proto_q   <= ip_proto_n;
				src_port_q   <= src_port_n;
				dst_port_q   <= dst_port_n;
				tcp_hdr_q    <= tcp_hdr_n;
				msg_tag_q    <= msg_tag_n;
				tag_seen_q   <= tag_seen_n;
				len_left_q   <= len_left_n;
				len_accum_q  <= len_accum_n;
				len_flag_q   <= len_flag_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < kfc_pkg::CNT_NUM; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (step && item.frame_end) begin
			cnt_q[kfc_pkg::CNT_TOTAL] <= cnt_q[kfc_pkg::CNT_TOTAL] + COUNT_BITS'(1);
			cnt_q[cls_slot]           <= cnt_q[cls_slot] + COUNT_BITS'(1);
			if (krb) begin
				cnt_q[kfc_pkg::CNT_KRB] <= cnt_q[kfc_pkg::CNT_KRB] + COUNT_BITS'(1);
			end
		end
	end

	assign cnt = cnt_q;

endmodule

### rtl/core/kfc_out_reg.sv
// kfc_out_reg: result register with valid, emptied by the downstream handshake
// uses kfc_pkg::result_t
module kfc_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  kfc_pkg::result_t load_data,
	input  logic             out_ready,
	output logic             out_valid,
	output kfc_pkg::result_t out_data,
	output logic             free
);

	logic             valid_q;
	kfc_pkg::result_t data_q;

	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end
	end

endmodule

### rtl/core/kfc_checker.sv
// kfc_checker: port-level assertions for the frame classifier
// uses kfc_pkg codes; bound to kerberos_frame_classifier at the end of this file
module kfc_checker #(
	parameter int COUNT_BITS = 32
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  res_valid,
	input logic                  res_ready,
	input logic [2:0]            proto_class,
	input logic                  is_kerberos,
	input logic [2:0]            message_kind,
	input logic                  length_ok,
	input logic [COUNT_BITS-1:0] total_frames,
	input logic [COUNT_BITS-1:0] kerberos_frames
);

	// a stalled result stays offered
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// kerberos traffic is always tcp
	a_krb_tcp: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && is_kerberos |-> proto_class == kfc_pkg::PC_TCP)
		else $error("kerberos flag on a non-tcp frame");

	// a message kind or decoded length only on kerberos frames, length only for as-req
	a_kind_krb: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (message_kind != kfc_pkg::MK_NONE || length_ok) |->
			is_kerberos && (!length_ok || message_kind == kfc_pkg::MK_AS_REQ))
		else $error("message fields on a frame that is not kerberos");

	// counters do not move while a result waits
	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(total_frames) && $stable(kerberos_frames))
		else $error("counters changed under a stalled result");

endmodule

bind kerberos_frame_classifier kfc_checker #(
	.COUNT_BITS (COUNT_BITS)
) u_kfc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.res_valid       (result.valid),
	.res_ready       (result.ready),
	.proto_class     (result.proto_class),
	.is_kerberos     (result.is_kerberos),
	.message_kind    (result.message_kind),
	.length_ok       (result.length_ok),
	.total_frames    (result.total_frames),
	.kerberos_frames (result.kerberos_frames)
);
